@@ sv/fault_blink_code_indicator_unit_assert.svh @@
// Assertion macros shared by the fault blink-code indicator RTL.
`ifndef FAULT_BLINK_CODE_INDICATOR_UNIT_ASSERT_SVH
`define FAULT_BLINK_CODE_INDICATOR_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FBCI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FBCI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/fbci_pkg.sv @@
// Package with the constants and register indexes of the fault blink-code indicator.
package fbci_pkg;

   localparam int unsigned CountWidth = 8;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CodeWidth = 4;
   localparam int unsigned TargetWidth = 5;
   localparam int unsigned ReqDataWidth = 8;
   localparam int unsigned RspDataWidth = 8;

   localparam logic [CsrIndexWidth-1:0] CsrErrorTickDivide = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrIdleToggleTicks = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrPauseUnits = 2'd2;

   localparam logic [CountWidth-1:0] ErrorTickDivideReset = 8'd20;
   localparam logic [CountWidth-1:0] IdleToggleTicksReset = 8'd50;
   localparam logic [CountWidth-1:0] PauseUnitsReset = 8'd10;

   localparam logic [CodeWidth-1:0] CodeNoFault = 4'd0;
   localparam logic [CodeWidth-1:0] CodeFirstNamed = 4'd1;
   localparam logic [CodeWidth-1:0] CodeLastNamed = 4'd12;
   localparam logic [TargetWidth-1:0] TargetMax = 5'd24;

endpackage

@@ sv/fault_blink_code_indicator_unit.sv @@
// Top level of the fault blink-code indicator: tick stream in, led and fg levels out.
// Each accepted tick transfer produces one result transfer holding the led and fg levels
// after that tick. The tick is evaluated in a single pass and its result is registered in
// the output register on acceptance; a new tick is taken in every cycle in which the output
// register is empty or its result is being taken, so the block sustains one tick per clock.
// Configuration writes through the csr port take effect at the clock edge of the write.
`include "fault_blink_code_indicator_unit_assert.svh"

module fault_blink_code_indicator_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [fbci_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [fbci_pkg::CountWidth-1:0]     csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Bit 0 is motor_running, bits 4:1 are fault_code; the user drives bits 7:5 zero, the block ignores them.
   input  logic [fbci_pkg::ReqDataWidth-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Bit 0 is led_level, bit 1 is fg_level, bits 7:2 are zero.
   output logic [fbci_pkg::RspDataWidth-1:0]   rsp_tdata
);

   logic [fbci_pkg::CountWidth-1:0] divide_ff;
   logic [fbci_pkg::CountWidth-1:0] idle_ticks_ff;
   logic [fbci_pkg::CountWidth-1:0] pause_ff;

   logic                               led_ff, led_in;
   logic                               fg_ff, fg_in;
   logic [fbci_pkg::CountWidth-1:0]    prescale_ff, prescale_in;
   logic [fbci_pkg::TargetWidth-1:0]   target_ff, target_in;
   logic [fbci_pkg::CountWidth-1:0]    phase_ff, phase_in;
   logic                               pause_phase_ff, pause_phase_in;
   logic [fbci_pkg::CountWidth-1:0]    idle_ff, idle_in;
   logic                               rsp_valid_ff;

   logic                               req_accept;
   logic                               running;
   logic [fbci_pkg::CodeWidth-1:0]     code;
   logic                               fire;
   logic [fbci_pkg::CountWidth:0]      phase_next;
   logic [fbci_pkg::CountWidth:0]      idle_next;

   assign running = req_tdata[0];
   assign code = req_tdata[fbci_pkg::CodeWidth:1];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign fire = (code != fbci_pkg::CodeNoFault) && (prescale_ff >= divide_ff);
   assign phase_next = {1'b0, phase_ff} + 1'b1;
   assign idle_next = {1'b0, idle_ff} + 1'b1;

   always_comb begin
      led_in = led_ff;
      fg_in = fg_ff;
      prescale_in = prescale_ff;
      target_in = target_ff;
      phase_in = phase_ff;
      pause_phase_in = pause_phase_ff;
      idle_in = idle_ff;
      if (code != fbci_pkg::CodeNoFault) begin
         if (!fire) begin
            prescale_in = prescale_ff + 1'b1;
         end else begin
            prescale_in = '0;
            if (code inside {[fbci_pkg::CodeFirstNamed : fbci_pkg::CodeLastNamed]}) begin
               target_in = {code, 1'b0};
            end
            if (!pause_phase_ff) begin
               led_in = !led_ff;
               fg_in = !fg_ff;
               if (phase_next >= {{(fbci_pkg::CountWidth + 1 - fbci_pkg::TargetWidth){1'b0}},
                                  target_in}) begin
                  phase_in = '0;
                  pause_phase_in = 1'b1;
               end else begin
                  phase_in = phase_next[fbci_pkg::CountWidth-1:0];
               end
            end else begin
               led_in = 1'b0;
               fg_in = 1'b1;
               if (phase_next >= {1'b0, pause_ff}) begin
                  phase_in = '0;
                  pause_phase_in = 1'b0;
               end else begin
                  phase_in = phase_next[fbci_pkg::CountWidth-1:0];
               end
            end
         end
      end else if (running) begin
         led_in = 1'b1;
      end else begin
         if (idle_next >= {1'b0, idle_ticks_ff}) begin
            idle_in = '0;
            led_in = !led_ff;
         end else begin
            idle_in = idle_next[fbci_pkg::CountWidth-1:0];
         end
         fg_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divide_ff <= fbci_pkg::ErrorTickDivideReset;
         idle_ticks_ff <= fbci_pkg::IdleToggleTicksReset;
         pause_ff <= fbci_pkg::PauseUnitsReset;
      end else if (csr_we) begin
         case (csr_index)
            fbci_pkg::CsrErrorTickDivide: divide_ff <= csr_wdata;
            fbci_pkg::CsrIdleToggleTicks: idle_ticks_ff <= csr_wdata;
            fbci_pkg::CsrPauseUnits: pause_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_ff <= 1'b0;
         fg_ff <= 1'b0;
         prescale_ff <= '0;
         target_ff <= '0;
         phase_ff <= '0;
         pause_phase_ff <= 1'b0;
         idle_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            led_ff <= led_in;
            fg_ff <= fg_in;
            prescale_ff <= prescale_in;
            target_ff <= target_in;
            phase_ff <= phase_in;
            pause_phase_ff <= pause_phase_in;
            idle_ff <= idle_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(fbci_pkg::RspDataWidth - 2){1'b0}}, fg_ff, led_ff};

   `FBCI_ASSERT_NOW(a_target_even, clock, reset, 1'b1,
      !target_ff[0] && target_ff <= fbci_pkg::TargetMax, "pulse target is odd or too large")
   `FBCI_ASSERT_NEXT(a_pause_levels, clock, reset, req_accept && fire && pause_phase_ff,
      rsp_tvalid && !rsp_tdata[0] && rsp_tdata[1], "pause unit did not drive led low and fg high")
   `FBCI_ASSERT_NEXT(a_running_led, clock, reset,
      req_accept && running && code == fbci_pkg::CodeNoFault,
      rsp_tvalid && rsp_tdata[0], "running without fault did not drive led high")
   `FBCI_ASSERT_NEXT(a_idle_fg, clock, reset,
      req_accept && !running && code == fbci_pkg::CodeNoFault,
      rsp_tvalid && !rsp_tdata[1], "stopped without fault did not drive fg low")
   `FBCI_ASSERT_NEXT(a_fault_keeps_idle, clock, reset,
      req_accept && code != fbci_pkg::CodeNoFault,
      idle_ff == $past(idle_ff), "idle counter moved during a fault tick")

endmodule
